// File: sv/rwhm_pkg.sv
// ============================================================================
// rwhm_pkg
// Shared types, widths and helpers for the random word health monitor.
// ============================================================================
package rwhm_pkg;

   localparam int WORD_W      = 32;
   localparam int TOTAL_W     = 38;
   localparam int BIN_W       = 32;
   localparam int BIN_COUNT   = 256;
   localparam int BIN_ADDR_W  = $clog2(BIN_COUNT);
   localparam int INTERVAL_W  = 24;
   localparam int CHANGED_W   = 6;
   localparam int EXPECT_W    = 26;
   localparam int BYTES       = WORD_W / 8;
   localparam int BYTE_IDX_W  = $clog2(BYTES);
   localparam int RSP_DATA_W  = 184;
   localparam int DIV_STEP_W  = $clog2(TOTAL_W);

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);
   localparam logic [CHANGED_W-1:0]  AVG_CLAMP      = CHANGED_W'(32);

   typedef struct packed {
      logic                 start;
      logic [TOTAL_W-1:0]   dividend;
      logic [WORD_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic                 busy;
      logic [TOTAL_W-1:0]   quotient;
      logic [WORD_W-1:0]    remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                  en;
      logic [BIN_ADDR_W-1:0] addr;
      logic [BIN_W-1:0]      data;
   } hist_wr_type;

   function automatic logic [CHANGED_W-1:0] ones_count(input logic [WORD_W-1:0] v);
      logic [CHANGED_W-1:0] c;
      c = '0;
      for (int i = 0; i < WORD_W; i++) begin
         c = c + CHANGED_W'(v[i]);
      end
      return c;
   endfunction

endpackage

// File: sv/rwhm_hist_ram.sv
// ============================================================================
// rwhm_hist_ram
// Byte histogram store: one write port, one registered read port, and a
// valid bit per bin so that bins never written read as zero after reset.
// ============================================================================
module rwhm_hist_ram (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rwhm_pkg::BIN_ADDR_W-1:0] rd_addr,
   output logic [rwhm_pkg::BIN_W-1:0]      rd_data,
   input  rwhm_pkg::hist_wr_type           wr
);
   import rwhm_pkg::*;

   logic [BIN_W-1:0]     bin_mem [BIN_COUNT];
   logic [BIN_COUNT-1:0] valid_ff;
   logic [BIN_W-1:0]     rd_mem_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         bin_mem[wr.addr] <= wr.data;
      end
      rd_mem_ff <= bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

endmodule

// File: sv/rwhm_divider.sv
// ============================================================================
// rwhm_divider
// Restoring radix-2 divider, one quotient bit per cycle. Serves both the
// average (total / count) and the report phase (count mod interval).
// ============================================================================
module rwhm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  rwhm_pkg::div_req_type div_req,
   output rwhm_pkg::div_rsp_type div_rsp
);
   import rwhm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [TOTAL_W-1:0]    quot_ff, quot_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [WORD_W-1:0]     divisor_ff, divisor_in;
   logic [WORD_W:0]       shifted;
   logic [WORD_W+1:0]     trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, quot_ff[TOTAL_W-1]};
      trial      = {1'b0, shifted} - {2'b00, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = DIV_STEP_W'(TOTAL_W - 1);
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // keep the difference when it did not borrow
         if (!trial[WORD_W+1]) begin
            rem_in  = trial[WORD_W-1:0];
            quot_in = {quot_ff[TOTAL_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[WORD_W-1:0];
            quot_in = {quot_ff[TOTAL_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.busy      = busy_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// File: sv/rng_word_health_monitor_unit.sv
// ============================================================================
// rng_word_health_monitor_unit
// Health statistics for a stream of random words: bit changes between words,
// running average, byte histogram with periodic min/max report.
// ============================================================================
// Sequence: a word is taken in IDLE; the result is registered after accumulate, a read
//   and a write per byte for 4 histogram bins, a 38-step serial division for the average,
//   a second one for the modulo unless the interval is 0, the bin scan on report words,
//   and emit. The priming word only sets the previous word and gives no result.
// Throughput: a new word is taken only in IDLE, once the last one has reached emit; this is
//   set by the shared serial divider and the single read port of the histogram memory. One
//   waiting result does not block input.
// Reset: synchronous; clears counters, interval to 1000, and all bin valid bits at once.
module rng_word_health_monitor_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rwhm_pkg::WORD_W-1:0]        req_tdata,  // random_word
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // word_echo, changed_bits, average_changed, word_count, expected_per_bin,
   // min_bin_index, min_bin_count, max_bin_index, max_bin_count, zero pad
   output logic [rwhm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,  // report_valid
   input  logic                               csr_we,
   input  logic [rwhm_pkg::INTERVAL_W-1:0]    csr_wdata   // report_interval
);
   import rwhm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_RD,
      ST_WR,
      ST_AVG,
      ST_AVG_WAIT,
      ST_MOD,
      ST_MOD_WAIT,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic                  primed_ff, primed_in;
   logic [WORD_W-1:0]     prev_ff, prev_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [CHANGED_W-1:0]  changed_ff, changed_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [WORD_W-1:0]     words_ff, words_in;
   logic [BYTE_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [CHANGED_W-1:0]  avg_ff, avg_in;
   logic                  report_ff, report_in;
   logic [BIN_ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [BIN_ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [BIN_W-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [BIN_ADDR_W-1:0] lo_i_ff, lo_i_in, hi_i_ff, hi_i_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [TOTAL_W:0]      total_sum;
   logic [BIN_ADDR_W-1:0] byte_addr;
   logic [BIN_ADDR_W-1:0] rd_addr;
   logic [BIN_W-1:0]      rd_data;
   hist_wr_type           hist_wr;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   rwhm_hist_ram u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (hist_wr)
   );

   rwhm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign byte_addr  = BIN_ADDR_W'(word_ff >> {byte_idx_ff, 3'b000});
   assign total_sum  = {1'b0, total_ff} + (TOTAL_W+1)'(changed_ff);

   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      prev_in      = prev_ff;
      word_in      = word_ff;
      changed_in   = changed_ff;
      total_in     = total_ff;
      words_in     = words_ff;
      byte_idx_in  = byte_idx_ff;
      avg_in       = avg_ff;
      report_in    = report_ff;
      scan_addr_in = scan_addr_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_i_in      = lo_i_ff;
      hi_i_in      = hi_i_ff;
      interval_in  = csr_we ? csr_wdata : interval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rd_addr      = '0;
      hist_wr      = '0;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               prev_in = req_tdata;
               if (!primed_ff) begin
                  primed_in = 1'b1;
               end else begin
                  word_in    = req_tdata;
                  changed_in = ones_count(prev_ff ^ req_tdata);
                  state_in   = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            words_in = (words_ff == '1) ? words_ff : words_ff + 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            rd_addr  = byte_addr;
            state_in = ST_WR;
         end
         ST_WR: begin
            hist_wr.en   = 1'b1;
            hist_wr.addr = byte_addr;
            hist_wr.data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
            byte_idx_in  = byte_idx_ff + 1'b1;
            state_in     = (byte_idx_ff == BYTE_IDX_W'(BYTES - 1)) ? ST_AVG : ST_RD;
         end
         ST_AVG: begin
            div_req.start    = 1'b1;
            div_req.dividend = total_ff;
            div_req.divisor  = words_ff;
            state_in         = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               avg_in = (div_rsp.quotient > TOTAL_W'(AVG_CLAMP)) ? AVG_CLAMP
                                                                : div_rsp.quotient[CHANGED_W-1:0];
               if (interval_ff == '0) begin
                  report_in = 1'b0;
                  state_in  = ST_EMIT;
               end else begin
                  state_in  = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            div_req.start    = 1'b1;
            div_req.dividend = TOTAL_W'(words_ff);
            div_req.divisor  = WORD_W'(interval_ff);
            state_in         = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               report_in = (div_rsp.remainder == '0);
               if (div_rsp.remainder == '0) begin
                  scan_addr_in = '0;
                  lo_in        = '1;
                  hi_in        = '0;
                  lo_i_in      = '0;
                  hi_i_in      = '0;
                  state_in     = ST_SCAN;
               end else begin
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            rd_addr      = scan_addr_ff;
            cmp_valid_in = 1'b1;
            cmp_idx_in   = scan_addr_ff;
            scan_addr_in = scan_addr_ff + 1'b1;
            if (scan_addr_ff == '1) begin
               state_in = ST_SCAN_TAIL;
            end
         end
         ST_SCAN_TAIL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold the result until the previous transfer has gone out
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = report_ff;
               rsp_data_in  = {2'b00,
                               report_ff ? hi_ff   : '0,
                               report_ff ? hi_i_ff : '0,
                               report_ff ? lo_ff   : '0,
                               report_ff ? lo_i_ff : '0,
                               words_ff[WORD_W-1:6],
                               words_ff, avg_ff, changed_ff, word_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // first strictly smaller / larger bin wins
      if (cmp_valid_ff) begin
         if (rd_data < lo_ff) begin
            lo_in   = rd_data;
            lo_i_in = cmp_idx_ff;
         end
         if (rd_data > hi_ff) begin
            hi_in   = rd_data;
            hi_i_in = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         prev_ff      <= '0;
         total_ff     <= '0;
         words_ff     <= '0;
         byte_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
         report_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         prev_ff      <= prev_in;
         total_ff     <= total_in;
         words_ff     <= words_in;
         byte_idx_ff  <= byte_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
         report_ff    <= report_in;
      end
      word_ff      <= word_in;
      changed_ff   <= changed_in;
      avg_ff       <= avg_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lo_i_ff      <= lo_i_in;
      hi_i_ff      <= hi_i_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_div_done_waited : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_AVG_WAIT || state_ff == ST_MOD_WAIT))
      else $error("divider result arrived outside a wait state");

   a_byte_idx_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (byte_idx_ff == '0))
      else $error("histogram byte index not back at zero in idle");

   a_no_report_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff[RSP_DATA_W-1:102] == '0))
      else $error("min/max fields set without a report");

   a_count_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (words_ff >= $past(words_ff)))
      else $error("word count went backward");

endmodule
